// ----- rtl/core/dxtd_pkg.sv -----
// dxtd_pkg: shared types, constants and arithmetic helpers of the dxt block decoder
// no dependencies; imported by the interfaces and every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package dxtd_pkg;

    typedef logic [11:0] coord_t;
    typedef logic [7:0]  chan_t;
    typedef logic [15:0] rgb565_t;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FORMAT_MODE = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;
    localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd4096;

    localparam logic MODE_DXT1 = 1'b0;
    localparam logic MODE_DXT5 = 1'b1;

    localparam int TEXELS = 16;
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    // one classified block as held between front and back
    typedef struct packed {
        coord_t                 block_x;
        coord_t                 block_y;
        logic [3:0][2:0][7:0]   color_pal;   // [entry][channel], channel 0 red
        logic [7:0][7:0]        alpha_pal;
        logic [31:0]            color_indices;
        logic [47:0]            alpha_indices;
        logic [TEXELS-1:0]      texel_mask;  // texels that lie inside the image
    } dxtd_block_t;

    // 5-bit channel to 8 bits: ((t/32 + t)/32), t = v*255 + 16
    function automatic chan_t widen5(input logic [4:0] v);
        logic [12:0] t;
        logic [12:0] s;
        t = 13'(v) * 13'd255 + 13'd16;
        s = (t >> 5) + t;
        return s[12:5];
    endfunction

    // 6-bit channel to 8 bits: ((t/64 + t)/64), t = v*255 + 32
    function automatic chan_t widen6(input logic [5:0] v);
        logic [13:0] t;
        logic [13:0] s;
        t = 14'(v) * 14'd255 + 14'd32;
        s = (t >> 6) + t;
        return s[13:6];
    endfunction

    // floor(v/3) for v below 768, by reciprocal multiply
    function automatic chan_t div3(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd683;
        return p[18:11];
    endfunction

    // floor(v/5) for v below 1280
    function automatic chan_t div5(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'd3277;
        return p[21:14];
    endfunction

    // floor(v/7) for v below 1792
    function automatic chan_t div7(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'd2341;
        return p[21:14];
    endfunction

    // one entry of the dxt5 alpha palette
    function automatic chan_t alpha_entry(input logic [2:0] code, input chan_t a0,
                                          input chan_t a1);
        logic [10:0] s7;
        logic [10:0] s5;
        chan_t       res;
        s7 = 11'(4'd8 - {1'b0, code}) * 11'(a0) + 11'(code - 3'd1) * 11'(a1);
        s5 = 11'(3'd6 - code) * 11'(a0) + 11'(code - 3'd1) * 11'(a1);
        if (code == 3'd0)
            res = a0;
        else if (code == 3'd1)
            res = a1;
        else if (a0 > a1)
            res = div7(s7);
        else if (code == 3'd6)
            res = 8'd0;
        else if (code == 3'd7)
            res = 8'd255;
        else
            res = div5(s5);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dxtd_if.sv -----
// dxtd_in_if and dxtd_out_if: valid/ready channels for compressed blocks and texels
// depends on dxtd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dxtd_in_if import dxtd_pkg::*; ();
    logic        valid;
    logic        ready;
    coord_t      block_x;
    coord_t      block_y;
    rgb565_t     color_endpoint0;
    rgb565_t     color_endpoint1;
    logic [31:0] color_indices;
    chan_t       alpha_endpoint0;
    chan_t       alpha_endpoint1;
    logic [47:0] alpha_indices;

    modport source (
        output valid, block_x, block_y, color_endpoint0, color_endpoint1,
               color_indices, alpha_endpoint0, alpha_endpoint1, alpha_indices,
        input  ready
    );
    modport sink (
        input  valid, block_x, block_y, color_endpoint0, color_endpoint1,
               color_indices, alpha_endpoint0, alpha_endpoint1, alpha_indices,
        output ready
    );
endinterface

interface dxtd_out_if import dxtd_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    chan_t  alpha;
    logic   last;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, alpha, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, alpha, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/dxt_texture_block_decoder_unit.sv -----
// dxt_texture_block_decoder_unit: dxt1/dxt5 4x4 block decoder, one texel out per cycle
// while the sink is ready; a taken request is written into the queue, and texels leave
// through the back end's output register; only the visible texels of a block are emitted,
// and a block wholly outside the image is dropped by the front and emits nothing
// reset: rst_n asynchronous, clears queue, walk state and output valid; format_mode -> dxt1,
// image_width -> 4096; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module dxt_texture_block_decoder_unit
    import dxtd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,

    // compressed block requests in, decoded texels out
    dxtd_in_if.sink                in_ch,
    dxtd_out_if.source             out_ch
);

    // configuration registers
    logic        format_mode_reg;
    logic        format_mode_next;
    logic [12:0] image_width_reg;
    logic [12:0] image_width_next;
    logic        cfg_write;

    // front to queue to back
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_head_valid;
    dxtd_block_t q_wr_entry;
    dxtd_block_t q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // registers sit at 4-byte spacing, paddr[2] picks one
    always_comb
    begin
        format_mode_next = format_mode_reg;
        image_width_next = image_width_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FORMAT_MODE: format_mode_next = pwdata[0];
                REG_IMAGE_WIDTH: image_width_next = pwdata[12:0];
                default:         format_mode_next = format_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FORMAT_MODE: prdata = {31'd0, format_mode_reg};
            REG_IMAGE_WIDTH: prdata = {19'd0, image_width_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= MODE_DXT1;
            image_width_reg <= IMAGE_WIDTH_RESET;
        end
        else
        begin
            format_mode_reg <= format_mode_next;
            image_width_reg <= image_width_next;
        end
    end

    // front: expands endpoints, builds both palettes and the visible texel mask;
    // it keeps taking requests while the queue has room, so a waiting texel on
    // the output holds the input side only once the queue is full
    dxtd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .in_ch       (in_ch),
        .format_mode (format_mode_reg),
        .image_width (image_width_reg),
        .q_full      (q_full),
        .push        (q_push),
        .entry       (q_wr_entry)
    );

    // two blocks of slack between front and back
    dxtd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_entry   (q_wr_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // back: steps through the visible texels of the head block in row order,
    // output register doubles as the skid stage towards the sink
    dxtd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dxtd_front.sv -----
// dxtd_front: takes a compressed block, builds colour and alpha palettes and texel mask
// depends on dxtd_pkg and dxtd_in_if
`timescale 1ns / 1ps
`default_nettype none

module dxtd_front
    import dxtd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    dxtd_in_if.sink     in_ch,
    input  wire logic   format_mode,
    input  wire logic [12:0] image_width,
    input  wire logic   q_full,
    output logic        push,
    output dxtd_block_t entry
);

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int XCW = (XW > 13) ? XW : 13;
    localparam int YCW = (YW > 13) ? YW : 13;

    logic [2:0][7:0] ep0;
    logic [2:0][7:0] ep1;
    logic            c0_gt_c1;
    logic [3:0]      col_ok;
    logic [3:0]      row_ok;
    logic [XCW-1:0]  col_x [4];
    logic [YCW-1:0]  row_y [4];

    assign in_ch.ready = !q_full;

    always_comb
    begin
        ep0[0] = widen5(in_ch.color_endpoint0[15:11]);
        ep0[1] = widen6(in_ch.color_endpoint0[10:5]);
        ep0[2] = widen5(in_ch.color_endpoint0[4:0]);
        ep1[0] = widen5(in_ch.color_endpoint1[15:11]);
        ep1[1] = widen6(in_ch.color_endpoint1[10:5]);
        ep1[2] = widen5(in_ch.color_endpoint1[4:0]);
    end

    assign c0_gt_c1 = in_ch.color_endpoint0 > in_ch.color_endpoint1;

    // column and row limits, computed without wrap
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            col_x[i]  = XCW'(in_ch.block_x) + XCW'(i);
            row_y[i]  = YCW'(in_ch.block_y) + YCW'(i);
            col_ok[i] = (col_x[i] < XCW'(image_width)) && (col_x[i] < XCW'(MAX_WIDTH));
            row_ok[i] = row_y[i] < YCW'(MAX_HEIGHT);
        end
    end

    always_comb
    begin
        entry.block_x       = in_ch.block_x;
        entry.block_y       = in_ch.block_y;
        entry.color_indices = in_ch.color_indices;
        entry.alpha_indices = in_ch.alpha_indices;
        for (int k = 0; k < TEXELS; k++)
            entry.texel_mask[k] = col_ok[k % 4] && row_ok[k / 4];
        for (int ch = 0; ch < 3; ch++)
        begin
            entry.color_pal[0][ch] = ep0[ch];
            entry.color_pal[1][ch] = ep1[ch];
            if (c0_gt_c1)
            begin
                entry.color_pal[2][ch] = div3({1'b0, ep0[ch], 1'b0} + 10'(ep1[ch]));
                entry.color_pal[3][ch] = 8'((9'(ep0[ch]) + 9'(ep1[ch])) >> 1);
            end
            else
            begin
                entry.color_pal[2][ch] = div3(10'(ep0[ch]) + {1'b0, ep1[ch], 1'b0});
                entry.color_pal[3][ch] = 8'd0;
            end
        end
        // dxt1 has opaque alpha whatever the code
        for (int c = 0; c < 8; c++)
        begin
            if (format_mode == MODE_DXT5)
                entry.alpha_pal[c] = alpha_entry(3'(c), in_ch.alpha_endpoint0,
                                                 in_ch.alpha_endpoint1);
            else
                entry.alpha_pal[c] = 8'd255;
        end
    end

    // blocks that lie wholly outside the image produce nothing and are dropped
    assign push = in_ch.valid && in_ch.ready && (entry.texel_mask != '0);

endmodule

`default_nettype wire

// ----- rtl/core/dxtd_queue.sv -----
// dxtd_queue: two-entry queue of classified blocks between front and back
// depends on dxtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dxtd_queue
    import dxtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire dxtd_block_t wr_entry,
    input  wire logic        pop,
    output logic             full,
    output logic             head_valid,
    output dxtd_block_t      head
);

    dxtd_block_t        entry_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QAW-1:0]     rd_ptr_next;
    logic [QAW:0]       count_reg;
    logic [QAW:0]       count_next;

    assign full       = count_reg == (QAW+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dxtd_back.sv -----
// dxtd_back: walks the texels of the head block and emits one texel a cycle while the sink is ready
// depends on dxtd_pkg and dxtd_out_if
`timescale 1ns / 1ps
`default_nettype none

module dxtd_back
    import dxtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire dxtd_block_t head,
    output logic             pop,
    dxtd_out_if.source       out_ch
);

    logic [TEXELS-1:0] done_reg;
    logic [TEXELS-1:0] done_next;
    logic [TEXELS-1:0] cur_mask;
    logic [TEXELS-1:0] rest_mask;
    logic [3:0]        sel_k;
    logic [5:0]        aidx_base;
    logic [1:0]        ci;
    logic [2:0]        ai;
    logic              advance;
    logic              is_last;

    logic   valid_reg;
    logic   valid_next;
    coord_t pixel_x_reg;
    coord_t pixel_y_reg;
    chan_t  red_reg;
    chan_t  green_reg;
    chan_t  blue_reg;
    chan_t  alpha_reg;
    logic   last_reg;

    assign cur_mask = head.texel_mask & ~done_reg;

    // lowest texel not yet emitted
    always_comb
    begin
        sel_k = '0;
        for (int k = TEXELS - 1; k >= 0; k--)
        begin
            if (cur_mask[k])
                sel_k = 4'(k);
        end
    end

    assign rest_mask = cur_mask & ~(TEXELS'(1) << sel_k);
    assign is_last   = rest_mask == '0;
    assign advance   = head_valid && (!valid_reg || out_ch.ready);
    assign pop       = advance && is_last;

    assign aidx_base = {2'b00, sel_k} + {1'b0, sel_k, 1'b0};
    assign ci        = head.color_indices[{sel_k, 1'b0} +: 2];
    assign ai        = head.alpha_indices[aidx_base +: 3];

    always_comb
    begin
        if (pop)
            done_next = '0;
        else if (advance)
            done_next = done_reg | (TEXELS'(1) << sel_k);
        else
            done_next = done_reg;

        if (advance)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_x_reg <= head.block_x + 12'(sel_k[1:0]);
            pixel_y_reg <= head.block_y + 12'(sel_k[3:2]);
            red_reg     <= head.color_pal[ci][0];
            green_reg   <= head.color_pal[ci][1];
            blue_reg    <= head.color_pal[ci][2];
            alpha_reg   <= head.alpha_pal[ai];
            last_reg    <= is_last;
        end
    end

    assign out_ch.valid   = valid_reg;
    assign out_ch.pixel_x = pixel_x_reg;
    assign out_ch.pixel_y = pixel_y_reg;
    assign out_ch.red     = red_reg;
    assign out_ch.green   = green_reg;
    assign out_ch.blue    = blue_reg;
    assign out_ch.alpha   = alpha_reg;
    assign out_ch.last    = last_reg;

endmodule

`default_nettype wire
